>>> rtl/bap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bap_pkg
// Shared types and constants for the block average pixellate block.
// ----------------------------------------------------------------------------
package bap_pkg;

  localparam int unsigned NREGS    = 8;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned COORD_W  = 20;
  localparam int unsigned TILE_W   = 9;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned QUOT_W   = 8;

  localparam logic [2:0] REG_BLOCK_W    = 3'd0;
  localparam logic [2:0] REG_BLOCK_H    = 3'd1;
  localparam logic [2:0] REG_OUT_TILE_W = 3'd2;
  localparam logic [2:0] REG_OUT_TILE_H = 3'd3;
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd4;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd5;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd6;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd7;

  // Controller to datapath commands.
  typedef struct packed {
    logic rd;       // read sum line for the current pixel
    logic wr;       // write accumulated sums back, latch tile info
    logic div_go;   // start dividers and rect math
    logic div_step; // advance dividers one bit
    logic load_out; // move results to the output register
  } bap_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic tile_done; // this pixel closes a tile
  } bap_sts_t;

endpackage
`default_nettype wire

>>> rtl/bap_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bap_pix_if / bap_res_if
// Valid/ready channels for source pixels and averaged tile results.
// ----------------------------------------------------------------------------
interface bap_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0;
  logic [7:0] chan1;
  logic [7:0] chan2;
  logic [7:0] chan3;
  modport source (output valid, chan0, chan1, chan2, chan3, input ready);
  modport sink   (input valid, chan0, chan1, chan2, chan3, output ready);
endinterface

interface bap_res_if;
  logic        valid;
  logic        ready;
  logic [19:0] dst_x;
  logic [19:0] dst_y;
  logic [8:0]  tile_w;
  logic [8:0]  tile_h;
  logic [7:0]  avg_c0;
  logic [7:0]  avg_c1;
  logic [7:0]  avg_c2;
  logic [7:0]  avg_c3;
  modport source (output valid, dst_x, dst_y, tile_w, tile_h,
                  avg_c0, avg_c1, avg_c2, avg_c3, input ready);
  modport sink   (input valid, dst_x, dst_y, tile_w, tile_h,
                  avg_c0, avg_c1, avg_c2, avg_c3, output ready);
endinterface
`default_nettype wire

>>> rtl/block_average_pixellate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_average_pixellate
// Mosaic downsampler: averages source tiles and emits destination rectangles.
// ----------------------------------------------------------------------------
// channel | dir | content
// pix     | in  | chan0..chan3 source pixel
// res     | out | dst_x, dst_y, tile_w, tile_h, avg_c0..avg_c3
// apb     | in  | eight config registers at 4*i
//
// Each pixel reads its line store entry, then accumulates and writes back.
// A pixel that closes a tile adds a bit-serial division of eight quotient
// bits and a handoff. The output register holds a result until taken; the
// block stalls before loading the next one. Reset is synchronous and clears
// counters and registers; the line store needs no clearing.
// ----------------------------------------------------------------------------
module block_average_pixellate
  import bap_pkg::*;
#(
  parameter int unsigned CHANNELS  = 4,
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned MAX_BLOCK = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  bap_pix_if.sink                pix,
  bap_res_if.source              res,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  logic [CFG_W-1:0] regs [NREGS];
  logic [2:0] ridx;
  assign ridx   = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_BLOCK_W]    <= 13'd8;
      regs[REG_BLOCK_H]    <= 13'd8;
      regs[REG_OUT_TILE_W] <= 13'd8;
      regs[REG_OUT_TILE_H] <= 13'd8;
      regs[REG_SRC_WIDTH]  <= 13'd640;
      regs[REG_SRC_HEIGHT] <= 13'd480;
      regs[REG_DST_WIDTH]  <= 13'd640;
      regs[REG_DST_HEIGHT] <= 13'd480;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_BLOCK_W, REG_BLOCK_H:       regs[ridx] <= {6'd0, pwdata[6:0]};
        REG_OUT_TILE_W, REG_OUT_TILE_H: regs[ridx] <= {4'd0, pwdata[8:0]};
        default:                        regs[ridx] <= pwdata[12:0];
      endcase
    end
  end

  assign prdata = {19'd0, regs[ridx]};

  bap_cmd_t cmd;
  bap_sts_t sts;
  logic [31:0] avg;
  logic out_busy;

  assign out_busy = res.valid && !res.ready;

  always_ff @(posedge clk) begin
    if (rst)                res.valid <= 1'b0;
    else if (cmd.load_out)  res.valid <= 1'b1;
    else if (res.ready)     res.valid <= 1'b0;
  end

  bap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix.valid),
    .in_ready (pix.ready),
    .out_busy (out_busy),
    .cmd      (cmd),
    .sts      (sts)
  );

  bap_datapath #(
    .CHANNELS  (CHANNELS),
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .pix        ({pix.chan3, pix.chan2, pix.chan1, pix.chan0}),
    .block_w    (regs[REG_BLOCK_W][6:0]),
    .block_h    (regs[REG_BLOCK_H][6:0]),
    .out_tile_w (regs[REG_OUT_TILE_W][8:0]),
    .out_tile_h (regs[REG_OUT_TILE_H][8:0]),
    .src_width  (regs[REG_SRC_WIDTH]),
    .src_height (regs[REG_SRC_HEIGHT]),
    .dst_width  (regs[REG_DST_WIDTH]),
    .dst_height (regs[REG_DST_HEIGHT]),
    .dst_x      (res.dst_x),
    .dst_y      (res.dst_y),
    .tile_w     (res.tile_w),
    .tile_h     (res.tile_h),
    .avg        (avg)
  );

  assign res.avg_c0 = avg[7:0];
  assign res.avg_c1 = avg[15:8];
  assign res.avg_c2 = avg[23:16];
  assign res.avg_c3 = avg[31:24];

endmodule
`default_nettype wire

>>> rtl/bap_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bap_ctrl
// Sequencer: read, accumulate, optional bit-serial divide, result handoff.
// ----------------------------------------------------------------------------
module bap_ctrl
  import bap_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     out_busy,
  output bap_cmd_t      cmd,
  input  wire bap_sts_t sts
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state, state_next;
  logic [4:0] step, step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.rd     = 1'b1;
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.wr = 1'b1;
        if (sts.tile_done) begin
          cmd.div_go = 1'b1;
          step_next  = 5'd0;
          state_next = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 5'd1;
        if (step == 5'(QUOT_W - 1)) state_next = ST_OUT;
      end
      default: begin
        if (!out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bap_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bap_datapath
// Position counters, column sum line store, restoring dividers, rect math.
// ----------------------------------------------------------------------------
module bap_datapath
  import bap_pkg::*;
#(
  parameter int unsigned CHANNELS  = 4,
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned MAX_BLOCK = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bap_cmd_t       cmd,
  output bap_sts_t            sts,
  input  wire logic [4*8-1:0] pix,
  input  wire logic [6:0]     block_w,
  input  wire logic [6:0]     block_h,
  input  wire logic [8:0]     out_tile_w,
  input  wire logic [8:0]     out_tile_h,
  input  wire logic [12:0]    src_width,
  input  wire logic [12:0]    src_height,
  input  wire logic [12:0]    dst_width,
  input  wire logic [12:0]    dst_height,
  output logic [COORD_W-1:0]  dst_x,
  output logic [COORD_W-1:0]  dst_y,
  output logic [TILE_W-1:0]   tile_w,
  output logic [TILE_W-1:0]   tile_h,
  output logic [4*8-1:0]      avg
);

  localparam int unsigned IDX_W = $clog2(MAX_WIDTH);
  localparam int unsigned BLK_W = $clog2(MAX_BLOCK + 1);
  localparam int unsigned PW    = IDX_W + 1;
  localparam int unsigned ROW_W = 12;
  localparam int unsigned SUM_B = $clog2(255 * MAX_BLOCK * MAX_BLOCK + 1);
  localparam int unsigned CNT_B = $clog2(MAX_BLOCK * MAX_BLOCK + 1);

  logic [IDX_W-1:0] pixel_col, tile_col;
  logic [ROW_W-1:0] pixel_row, tile_row;
  logic [BLK_W-1:0] col_in_tile, row_in_tile;

  // Clamped configuration.
  logic [BLK_W:0]  bw, bh;
  logic [8:0]      ow, oh;
  logic [PW-1:0]   sw;
  logic [12:0]     sh;
  always_comb begin
    bw = (block_w == '0) ? (BLK_W+1)'(1) :
         ({6'd0, block_w} > 13'(MAX_BLOCK)) ? (BLK_W+1)'(MAX_BLOCK) : (BLK_W+1)'(block_w);
    bh = (block_h == '0) ? (BLK_W+1)'(1) :
         ({6'd0, block_h} > 13'(MAX_BLOCK)) ? (BLK_W+1)'(MAX_BLOCK) : (BLK_W+1)'(block_h);
    ow = (out_tile_w > 9'd256) ? 9'd256 : out_tile_w;
    oh = (out_tile_h > 9'd256) ? 9'd256 : out_tile_h;
    sw = (src_width == '0) ? PW'(1) :
         ({7'd0, src_width} > 20'(MAX_WIDTH)) ? PW'(MAX_WIDTH) : PW'(src_width);
    sh = (src_height == '0) ? 13'd1 :
         (src_height > 13'd4096) ? 13'd4096 : src_height;
  end

  logic last_col, last_row, row_end, first;
  logic [BLK_W:0] cit1, rit1;
  logic [PW-1:0]  pc1;
  logic [12:0]    pr1;
  assign cit1     = (BLK_W+1)'(col_in_tile) + 1'b1;
  assign rit1     = (BLK_W+1)'(row_in_tile) + 1'b1;
  assign pc1      = PW'(pixel_col) + 1'b1;
  assign pr1      = 13'(pixel_row) + 1'b1;
  assign row_end  = (pc1 >= sw);
  assign last_col = (cit1 >= bw) || row_end;
  assign last_row = (rit1 >= bh) || (pr1 >= sh);
  assign first    = (col_in_tile == '0) && (row_in_tile == '0);
  assign sts.tile_done = last_col && last_row;

  // Line store, four channels per row of memory.
  logic [4*SUM_B-1:0] mem [MAX_WIDTH];
  logic [4*SUM_B-1:0] rd_data, wr_data;
  logic [4*8-1:0]     pix_q;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= mem[tile_col];
      pix_q   <= pix;
    end
    if (cmd.wr) mem[tile_col] <= wr_data;
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (c >= CHANNELS)
        wr_data[c*SUM_B +: SUM_B] = '0;
      else if (first)
        wr_data[c*SUM_B +: SUM_B] = SUM_B'(pix_q[c*8 +: 8]);
      else
        wr_data[c*SUM_B +: SUM_B] = rd_data[c*SUM_B +: SUM_B] +
                                    SUM_B'(pix_q[c*8 +: 8]);
    end
  end

  // Position counters advance on the write cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_col <= '0; pixel_row <= '0; tile_col <= '0; tile_row <= '0;
      col_in_tile <= '0; row_in_tile <= '0;
    end else if (cmd.wr) begin
      if (row_end) begin
        pixel_col <= '0; col_in_tile <= '0; tile_col <= '0;
        if (pr1 >= sh) begin
          pixel_row <= '0; row_in_tile <= '0; tile_row <= '0;
        end else begin
          pixel_row <= pixel_row + 1'b1;
          if (rit1 >= bh) begin
            row_in_tile <= '0;
            tile_row    <= tile_row + 1'b1;
          end else begin
            row_in_tile <= row_in_tile + 1'b1;
          end
        end
      end else begin
        pixel_col <= pixel_col + 1'b1;
        if (last_col) begin
          col_in_tile <= '0;
          tile_col    <= tile_col + 1'b1;
        end else begin
          col_in_tile <= col_in_tile + 1'b1;
        end
      end
    end
  end

  // Divide phase. The sum is below 256 times the pixel count, so the high
  // part seeds the remainder and only the eight quotient bits are produced.
  logic [4*CNT_B-1:0]  rem;
  logic [4*QUOT_W-1:0] quo;
  logic [CNT_B-1:0]    cnt;
  logic [COORD_W-1:0]  dx, dy;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      for (int c = 0; c < 4; c++) begin
        quo[c*QUOT_W +: QUOT_W] <= wr_data[c*SUM_B +: QUOT_W];
        rem[c*CNT_B +: CNT_B]   <= CNT_B'(wr_data[c*SUM_B +: SUM_B] >> QUOT_W);
      end
    end
    // Counters still hold the closing pixel's position on this edge.
    if (cmd.div_go) begin
      cnt <= CNT_B'(cit1) * CNT_B'(rit1);
      dx  <= COORD_W'(tile_col) * COORD_W'(ow);
      dy  <= COORD_W'(tile_row) * COORD_W'(oh);
    end
    if (cmd.div_step) begin
      for (int c = 0; c < 4; c++) begin
        logic [CNT_B:0] t;
        t = {rem[c*CNT_B +: CNT_B], quo[c*QUOT_W + QUOT_W - 1]};
        if (t >= (CNT_B+1)'(cnt)) begin
          rem[c*CNT_B +: CNT_B]   <= CNT_B'(t - (CNT_B+1)'(cnt));
          quo[c*QUOT_W +: QUOT_W] <= {quo[c*QUOT_W +: QUOT_W-1], 1'b1};
        end else begin
          rem[c*CNT_B +: CNT_B]   <= CNT_B'(t);
          quo[c*QUOT_W +: QUOT_W] <= {quo[c*QUOT_W +: QUOT_W-1], 1'b0};
        end
      end
    end
  end

  function automatic logic [TILE_W-1:0] clip_len(input logic [COORD_W-1:0] o,
                                                 input logic [8:0] len,
                                                 input logic [12:0] lim);
    logic [COORD_W:0] e;
    e = (COORD_W+1)'(o) + (COORD_W+1)'(len);
    if (o >= COORD_W'(lim))             clip_len = '0;
    else if (e > (COORD_W+1)'(lim))     clip_len = TILE_W'(COORD_W'(lim) - o);
    else                                clip_len = len;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      dst_x  <= dx;
      dst_y  <= dy;
      tile_w <= clip_len(dx, ow, dst_width);
      tile_h <= clip_len(dy, oh, dst_height);
      for (int c = 0; c < 4; c++)
        avg[c*8 +: 8] <= quo[c*QUOT_W +: QUOT_W];
    end
  end

endmodule
`default_nettype wire
